@@ design/spmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types for the strict-priority multilevel queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

endpackage

@@ design/spmq_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_in_if
// Request channel: valid/ready handshake with operation, level and entry id.
// ----------------------------------------------------------------------------
interface spmq_in_if #(
    parameter int LW  = 3,
    parameter int IDW = 16
);
    logic              valid;
    logic              ready;
    spmq_pkg::op_t     kind;
    logic [LW-1:0]     level;
    logic [IDW-1:0]    entry_in;

    modport source (output valid, output kind, output level, output entry_in, input ready);
    modport sink   (input valid, input kind, input level, input entry_in, output ready);
endinterface

@@ design/spmq_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_out_if
// Result channel: valid/ready handshake with removed entry and queue status.
// ----------------------------------------------------------------------------
interface spmq_out_if #(
    parameter int LW  = 3,
    parameter int CW  = 5,
    parameter int IDW = 16
);
    logic              valid;
    logic              ready;
    logic [IDW-1:0]    entry_out;
    logic              entry_valid;
    logic [LW-1:0]     served_level;
    logic [CW-1:0]     level_count;
    logic              level_empty;
    logic              all_empty;
    logic              dropped;

    modport source (output valid, output entry_out, output entry_valid, output served_level,
                    output level_count, output level_empty, output all_empty,
                    output dropped, input ready);
    modport sink   (input valid, input entry_out, input entry_valid, input served_level,
                    input level_count, input level_empty, input all_empty,
                    input dropped, output ready);
endinterface

@@ design/strict_priority_multi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Strict-priority multilevel FIFO: LEVELS queues of DEPTH entries each.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time: at accept the per-level pointers
// and counts are updated and the shared entry store is written (insert)
// or read (remove); the store's read data is registered and the result is
// then loaded into the output register, when that register is free. A
// finished result may wait in that register while the next transaction
// is taken. Inserts to a full queue or to a level outside 1..LEVELS are
// dropped and flagged; a remove with every queue empty returns no entry.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue #(
    parameter int LEVELS   = 4,
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    spmq_in_if.sink    in_ch,
    spmq_out_if.source out_ch
);
    import spmq_pkg::*;

    localparam int LW      = $clog2(LEVELS + 1);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    logic                busy_reg;
    logic                out_valid_reg;
    logic [ID_WIDTH-1:0] entry_out_reg;
    logic                entry_valid_reg;
    logic [LW-1:0]       served_reg;
    logic [CW-1:0]       count_reg;
    logic                level_empty_reg;
    logic                all_empty_reg;
    logic                dropped_reg;

    logic                acc;
    logic                load;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [ID_WIDTH-1:0] mem_rdata;
    logic                st_valid;
    logic [LW-1:0]       st_served;
    logic [CW-1:0]       st_count;
    logic                st_all_empty;
    logic                st_dropped;

    assign in_ch.ready = !busy_reg;
    assign acc         = in_ch.valid && !busy_reg;
    assign load        = busy_reg && (!out_valid_reg || out_ch.ready);

    spmq_ctrl #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH),
        .IDW    (ID_WIDTH),
        .LW     (LW),
        .CW     (CW),
        .AW     (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .kind         (in_ch.kind),
        .level        (in_ch.level),
        .entry_in     (in_ch.entry_in),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .st_valid     (st_valid),
        .st_served    (st_served),
        .st_count     (st_count),
        .st_all_empty (st_all_empty),
        .st_dropped   (st_dropped)
    );

    spmq_store #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .IDW     (ID_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_out_reg   <= st_valid ? mem_rdata : '0;
            entry_valid_reg <= st_valid;
            served_reg      <= st_served;
            count_reg       <= st_count;
            level_empty_reg <= (st_count == '0);
            all_empty_reg   <= st_all_empty;
            dropped_reg     <= st_dropped;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.entry_out    = entry_out_reg;
    assign out_ch.entry_valid  = entry_valid_reg;
    assign out_ch.served_level = served_reg;
    assign out_ch.level_count  = count_reg;
    assign out_ch.level_empty  = level_empty_reg;
    assign out_ch.all_empty    = all_empty_reg;
    assign out_ch.dropped      = dropped_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (busy_reg && !acc))
        else $error("second transaction taken while one in flight");

    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_valid_reg) |=> (!busy_reg && out_valid_reg))
        else $error("result not loaded into free output register");

    a_remove_served: assert property (@(posedge clk) disable iff (!rst_n)
        (load && st_valid) |-> (st_served != '0 && !st_dropped))
        else $error("served entry without a level");

endmodule

@@ design/spmq_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_store
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spmq_store #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6,
    parameter int IDW     = 16
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  logic [IDW-1:0] wdata,
    input  logic           re,
    input  logic [AW-1:0]  raddr,
    output logic [IDW-1:0] rdata
);

    logic [IDW-1:0] mem [ENTRIES];
    logic [IDW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/spmq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_ctrl
// Per-level head/tail/count file, priority select and store access issue.
// Status for the result is staged at accept, in step with the registered read data.
// ----------------------------------------------------------------------------
module spmq_ctrl #(
    parameter int LEVELS = 4,
    parameter int DEPTH  = 16,
    parameter int IDW    = 16,
    parameter int LW     = 3,
    parameter int CW     = 5,
    parameter int AW     = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           acc,
    input  spmq_pkg::op_t  kind,
    input  logic [LW-1:0]  level,
    input  logic [IDW-1:0] entry_in,
    output logic           mem_we,
    output logic [AW-1:0]  mem_waddr,
    output logic [IDW-1:0] mem_wdata,
    output logic           mem_re,
    output logic [AW-1:0]  mem_raddr,
    output logic           st_valid,
    output logic [LW-1:0]  st_served,
    output logic [CW-1:0]  st_count,
    output logic           st_all_empty,
    output logic           st_dropped
);
    import spmq_pkg::*;

    localparam int QW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PW-1:0] head_reg  [LEVELS];
    logic [PW-1:0] tail_reg  [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    logic [CW-1:0] count_next [LEVELS];

    logic          st_valid_reg;
    logic [LW-1:0] st_served_reg;
    logic [CW-1:0] st_count_reg;
    logic          st_all_empty_reg;
    logic          st_dropped_reg;

    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] nonempty_next;
    logic              any_ready;
    logic [QW-1:0]     sq;
    logic [LW-1:0]     lv_m1;
    logic [QW-1:0]     lq;
    logic              lv_ok;
    logic              is_ins;
    logic              ins_ok;
    logic              rm_ok;
    logic [PW-1:0]     tail_sel;
    logic [PW-1:0]     head_sel;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
        any_ready = |nonempty;
        sq        = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                sq = QW'(i);
            end
        end
    end

    assign lv_m1    = level - LW'(1);
    assign lq       = lv_m1[QW-1:0];
    assign lv_ok    = (level != '0) && (32'(level) <= LEVELS);
    assign is_ins   = (kind == OP_INSERT);
    assign ins_ok   = is_ins && lv_ok && (count_reg[lq] != CW'(DEPTH));
    assign rm_ok    = !is_ins && any_ready;
    assign tail_sel = tail_reg[lq];
    assign head_sel = head_reg[sq];

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            count_next[i] = count_reg[i];
            if (ins_ok && (lq == QW'(i)))
            begin
                count_next[i] = count_reg[i] + CW'(1);
            end
            if (rm_ok && (sq == QW'(i)))
            begin
                count_next[i] = count_reg[i] - CW'(1);
            end
            nonempty_next[i] = (count_next[i] != '0);
        end
    end

    assign mem_we    = acc && ins_ok;
    assign mem_waddr = AW'(lq) * AW'(DEPTH) + AW'(tail_sel);
    assign mem_wdata = entry_in;
    assign mem_re    = acc && rm_ok;
    assign mem_raddr = AW'(sq) * AW'(DEPTH) + AW'(head_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (acc)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
            if (ins_ok)
            begin
                tail_reg[lq] <= (32'(tail_sel) == DEPTH - 1) ? '0 : tail_sel + PW'(1);
            end
            if (rm_ok)
            begin
                head_reg[sq] <= (32'(head_sel) == DEPTH - 1) ? '0 : head_sel + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            st_valid_reg     <= rm_ok;
            st_served_reg    <= rm_ok ? LW'(sq) + LW'(1) : '0;
            st_count_reg     <= lv_ok ? count_next[lq] : '0;
            st_all_empty_reg <= (nonempty_next == '0);
            st_dropped_reg   <= is_ins && !ins_ok;
        end
    end

    assign st_valid     = st_valid_reg;
    assign st_served    = st_served_reg;
    assign st_count     = st_count_reg;
    assign st_all_empty = st_all_empty_reg;
    assign st_dropped   = st_dropped_reg;

    a_no_dual_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store written and read by one transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg[0]) <= DEPTH)
        else $error("level fill count beyond depth");

    a_all_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        $past(acc) |-> (st_all_empty_reg == (nonempty == '0)))
        else $error("all-empty status disagrees with counts");

endmodule

@@ verif/strict_priority_multi_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_tb
// Self-checking testbench for the strict-priority multilevel queue.
// A table of directed transactions covers empty removes, out-of-range levels,
// extreme ids and a full level. Random traffic follows in insert- and
// remove-heavy bursts. The traffic runs under changing sender and receiver
// idle rates, with one long receiver hold-off. Every result is compared field
// by field against a queue-per-level predictor or a table row's typed status.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_tb;

    import spmq_pkg::*;

    localparam int LEVELS      = 4;
    localparam int DEPTH       = 16;
    localparam int ID_WIDTH    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ID_WIDTH-1:0] entry_out;
        logic                entry_valid;
        logic [2:0]          served_level;
        logic [4:0]          level_count;
        logic                level_empty;
        logic                all_empty;
        logic                dropped;
    } status_t;

    typedef struct {
        op_t                 op;
        logic [2:0]          lv;
        logic [ID_WIDTH-1:0] id;
        int                  reps;
        bit                  typed;
        status_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    spmq_in_if  #(.LW(3), .IDW(ID_WIDTH))          in_ch ();
    spmq_out_if #(.LW(3), .CW(5), .IDW(ID_WIDTH))  out_ch ();

    strict_priority_multi_queue #(
        .LEVELS   (LEVELS),
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [ID_WIDTH-1:0] level_fifo [LEVELS][$];
    status_t             pending_status [$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_request;
    int error_count;
    int cycle_count;
    int items_sent;
    int results_seen;
    int drops_full;
    int drops_bad_level;
    int empty_removes;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function automatic status_t predict_queue_op(op_t op, logic [2:0] lv,
                                                 logic [ID_WIDTH-1:0] id);
        status_t r;
        bit      lv_ok;
        r     = '0;
        lv_ok = (lv >= 1) && (lv <= LEVELS);
        if (op == OP_INSERT)
        begin
            if (!lv_ok)
            begin
                r.dropped = 1'b1;
                drops_bad_level++;
            end
            else if (level_fifo[lv-1].size() >= DEPTH)
            begin
                r.dropped = 1'b1;
                drops_full++;
            end
            else
                level_fifo[lv-1].push_back(id);
        end
        else
        begin
            for (int q = 0; q < LEVELS; q++)
            begin
                if (level_fifo[q].size() != 0)
                begin
                    r.entry_out    = level_fifo[q].pop_front();
                    r.entry_valid  = 1'b1;
                    r.served_level = 3'(q + 1);
                    break;
                end
            end
            if (!r.entry_valid)
                empty_removes++;
        end
        if (lv_ok)
            r.level_count = 5'(level_fifo[lv-1].size());
        r.level_empty = (r.level_count == 0);
        r.all_empty   = 1'b1;
        for (int q = 0; q < LEVELS; q++)
            if (level_fifo[q].size() != 0)
                r.all_empty = 1'b0;
        return r;
    endfunction

    // valid is left high after acceptance so back-to-back transactions never
    // lower and raise it within one time step
    task automatic send_item(op_t op, logic [2:0] lv, logic [ID_WIDTH-1:0] id,
                             bit use_typed, status_t typed_want);
        status_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= op;
        in_ch.level    <= lv;
        in_ch.entry_in <= id;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = predict_queue_op(op, lv, id);
        pending_status.push_back(use_typed ? typed_want : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(int count);
        int         insert_pct;
        int         pick;
        op_t        op;
        logic [2:0] lv;
        insert_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(3))
                    0:       insert_pct = 30;
                    1:       insert_pct = 50;
                    2:       insert_pct = 70;
                    default: insert_pct = 90;
                endcase
            end
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            if ($urandom_range(99) < 6)
            begin
                pick = $urandom_range(3);
                lv   = (pick == 0) ? 3'd0 : 3'(pick + 4);
            end
            else
                lv = 3'($urandom_range(LEVELS, 1));
            send_item(op, lv, ID_WIDTH'($urandom), 1'b0, '0);
        end
    endtask

    // receiver: random stalls, plus a long hold-off counted here on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        status_t seen;
        status_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen = '{out_ch.entry_out, out_ch.entry_valid, out_ch.served_level,
                     out_ch.level_count, out_ch.level_empty, out_ch.all_empty,
                     out_ch.dropped};
            results_seen++;
            if (pending_status.size() == 0)
                report_error($sformatf("result %0h with no transaction pending", seen));
            else
            begin
                want = pending_status.pop_front();
                if (seen.entry_out !== want.entry_out)
                    report_error($sformatf("entry_out got %0h want %0h",
                                           seen.entry_out, want.entry_out));
                if (seen.entry_valid !== want.entry_valid)
                    report_error($sformatf("entry_valid got %0b want %0b",
                                           seen.entry_valid, want.entry_valid));
                if (seen.served_level !== want.served_level)
                    report_error($sformatf("served_level got %0d want %0d",
                                           seen.served_level, want.served_level));
                if (seen.level_count !== want.level_count)
                    report_error($sformatf("level_count got %0d want %0d",
                                           seen.level_count, want.level_count));
                if (seen.level_empty !== want.level_empty)
                    report_error($sformatf("level_empty got %0b want %0b",
                                           seen.level_empty, want.level_empty));
                if (seen.all_empty !== want.all_empty)
                    report_error($sformatf("all_empty got %0b want %0b",
                                           seen.all_empty, want.all_empty));
                if (seen.dropped !== want.dropped)
                    report_error($sformatf("dropped got %0b want %0b",
                                           seen.dropped, want.dropped));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_status.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed_rows [11];
        stim_row_t row;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = OP_INSERT;
        in_ch.level     = '0;
        in_ch.entry_in  = '0;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        hold_request    = 0;
        error_count     = 0;
        cycle_count     = 0;
        items_sent      = 0;
        results_seen    = 0;
        drops_full      = 0;
        drops_bad_level = 0;
        empty_removes   = 0;

        //                  op         lv    id       reps typed  want
        directed_rows = '{
            '{OP_REMOVE, 3'd1, 16'h0000, 1, 1'b1, '{16'h0000, 1'b0, 3'd0, 5'd0, 1'b1, 1'b1, 1'b0}},
            '{OP_INSERT, 3'd0, 16'hFFFF, 1, 1'b1, '{16'h0000, 1'b0, 3'd0, 5'd0, 1'b1, 1'b1, 1'b1}},
            '{OP_INSERT, 3'd7, 16'h0000, 1, 1'b1, '{16'h0000, 1'b0, 3'd0, 5'd0, 1'b1, 1'b1, 1'b1}},
            '{OP_INSERT, 3'd1, 16'hFFFF, 1, 1'b1, '{16'h0000, 1'b0, 3'd0, 5'd1, 1'b0, 1'b0, 1'b0}},
            '{OP_INSERT, 3'd4, 16'h0000, 1, 1'b1, '{16'h0000, 1'b0, 3'd0, 5'd1, 1'b0, 1'b0, 1'b0}},
            '{OP_INSERT, 3'd2, 16'hA5A5, 1, 1'b0, '0},
            '{OP_REMOVE, 3'd0, 16'h5A5A, 1, 1'b0, '0},
            '{OP_REMOVE, 3'd5, 16'h0000, 1, 1'b0, '0},
            '{OP_REMOVE, 3'd4, 16'hFFFF, 1, 1'b0, '0},
            '{OP_INSERT, 3'd3, 16'h8000, DEPTH, 1'b0, '0},
            '{OP_INSERT, 3'd3, 16'h7FFF, 1, 1'b1, '{16'h0000, 1'b0, 3'd0, 5'd16, 1'b0, 1'b0, 1'b1}}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
                send_item(row.op, row.lv, ID_WIDTH'(row.id + k), row.typed, row.want);
        end
        drain_results();

        src_idle_pct  = 25;
        sink_idle_pct = 54;
        run_random(520);
        drain_results();

        src_idle_pct  = 54;
        sink_idle_pct = 25;
        run_random(520);

        // receiver stalls for a long stretch while transactions keep coming
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        run_random(60);
        drain_results();

        run_random(520);
        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d transactions, checked %0d results", items_sent, results_seen);
        $display("Drops on full level %0d, on bad level %0d; removes from empty %0d",
                 drops_full, drops_bad_level, empty_removes);
        if (error_count == 0 && pending_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
